[sv/ped_pkg.sv]
// shared types and constants of the periodic event dispatcher
package ped_pkg;

    localparam int DEF_MAX_EVENTS = 16;
    localparam int DEF_TIME_BITS  = 48;

    localparam int CMD_W    = 2;
    localparam int PMS_W    = 20;
    localparam int PERIOD_W = 30;
    localparam int RUNS_W   = 32;
    localparam int ID_W     = 4;
    localparam int US_PER_MS = 1000;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_REGISTER = 2'd1,
        CMD_PROCESS  = 2'd2,
        CMD_NOP      = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WRITE,
        ST_PREP,
        ST_SCAN,
        ST_DONE
    } t_state;

    // per-cell control
    typedef struct packed {
        logic shift;
        logic load;
        logic clr_q;
    } t_cell_ctl;

endpackage

[sv/ped_ram.sv]
// generic single-write, single-read ram with registered read data
module ped_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/ped_cell.sv]
// one event table cell: period, due time, queued mark and run count
module ped_cell
    import ped_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    // neighbor entry, taken on shift
    input  logic [PERIOD_W-1:0]  i_nb_period,
    input  logic [TIME_BITS-1:0] i_nb_due,
    input  logic                 i_nb_queued,
    input  logic [RUNS_W-1:0]    i_nb_runs,
    // fresh entry, taken on load
    input  logic [PERIOD_W-1:0]  i_wr_period,
    input  logic [TIME_BITS-1:0] i_wr_due,
    output logic [PERIOD_W-1:0]  o_period,
    output logic [TIME_BITS-1:0] o_due,
    output logic                 o_queued,
    output logic [RUNS_W-1:0]    o_runs
);

    logic [PERIOD_W-1:0]  r_period;
    logic [TIME_BITS-1:0] r_due;
    logic                 r_queued;
    logic [RUNS_W-1:0]    r_runs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued <= 1'b0;
        end else if (i_ctl.clr_q) begin
            r_queued <= 1'b0;
        end else if (i_ctl.shift) begin
            r_queued <= i_nb_queued;
        end else if (i_ctl.load) begin
            r_queued <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_period <= i_nb_period;
            r_due    <= i_nb_due;
            r_runs   <= i_nb_runs;
        end else if (i_ctl.load) begin
            // registering counts as the first run
            r_period <= i_wr_period;
            r_due    <= i_wr_due;
            r_runs   <= RUNS_W'(1);
        end
    end

    assign o_period = r_period;
    assign o_due    = r_due;
    assign o_queued = r_queued;
    assign o_runs   = r_runs;

endmodule

[sv/periodic_event_dispatcher.sv]
// top level of the periodic event dispatcher: cell ring, run queue and control
//
// Keeps a table of up to MAX_EVENTS periodic events in a ring of cells and a
// FIFO run queue in a small ram. Each input transaction is a command carrying
// the current time: clear empties table and queue; register appends an event
// (period in ms, scaled to us), runs it at once and schedules it at now plus
// period, or answers result_status 1 when the table is full; process walks
// the table in index order, queues every due event not yet queued (due when
// due minus now, as a signed wrap difference, is zero or negative), then
// runs the queue head, bumps its run count and reschedules it. Exactly one
// result transaction per input transaction. A process command rotates the
// ring once past cell 0, one entry per cycle; a register goes through a
// multiplier stage, then the table write. One command is in work at a
// time; a finished result waits in the output register, so the next
// command is taken while it is still stalled.
module periodic_event_dispatcher
    import ped_pkg::*;
#(
    parameter int MAX_EVENTS = DEF_MAX_EVENTS,
    parameter int TIME_BITS  = DEF_TIME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [PMS_W-1:0]     i_period_ms,
    input  logic [TIME_BITS-1:0] i_now_us,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_dispatched,
    output logic [ID_W-1:0]      o_event_id,
    output logic [RUNS_W-1:0]    o_run_total,
    output logic                 o_result_status
);

    localparam int IDX_W = $clog2(MAX_EVENTS);
    localparam int CNT_W = $clog2(MAX_EVENTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_EVENTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_EVENTS);

    // control state
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_used, n_used;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_out_valid, n_out_valid;

    // per-command working registers
    logic [PMS_W-1:0]     r_pms, n_pms;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [PERIOD_W-1:0]  r_period_calc, n_period_calc;
    logic [IDX_W-1:0]     r_k, n_k;
    logic [IDX_W-1:0]     r_pop_idx, n_pop_idx;
    logic                 r_fifo_had, n_fifo_had;
    logic                 r_got, n_got;

    // result being built, then the output register
    logic                 r_res_disp, n_res_disp;
    logic [ID_W-1:0]      r_res_id, n_res_id;
    logic [RUNS_W-1:0]    r_res_runs, n_res_runs;
    logic                 r_res_status, n_res_status;
    logic                 r_out_disp, n_out_disp;
    logic [ID_W-1:0]      r_out_id, n_out_id;
    logic [RUNS_W-1:0]    r_out_runs, n_out_runs;
    logic                 r_out_status, n_out_status;

    // cell ring
    t_cell_ctl            w_ctl     [MAX_EVENTS];
    logic [PERIOD_W-1:0]  w_period  [MAX_EVENTS];
    logic [TIME_BITS-1:0] w_due     [MAX_EVENTS];
    logic                 w_queued  [MAX_EVENTS];
    logic [RUNS_W-1:0]    w_runs    [MAX_EVENTS];

    // entry at cell 0 after processing, fed back into the last cell
    logic [TIME_BITS-1:0] w_back_due;
    logic                 w_back_queued;
    logic [RUNS_W-1:0]    w_back_runs;

    logic                 w_in_acc;
    logic                 w_res_load;
    logic [TIME_BITS-1:0] w_add_opnd;
    logic [TIME_BITS-1:0] w_new_due;
    logic [TIME_BITS-1:0] w_diff;
    logic                 w_in_use;
    logic                 w_is_due;
    logic                 w_cand;
    logic                 w_disp;
    logic                 w_append;
    logic                 w_pop;
    logic [RUNS_W-1:0]    w_runs_inc;
    logic [IDX_W-1:0]     w_rd_idx;
    logic                 w_ram_we;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    // result moves to the output register once that register is free
    assign w_res_load = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    // one adder serves both the register write and the reschedule
    assign w_add_opnd = (r_state == ST_SCAN) ? TIME_BITS'(w_period[0])
                                             : TIME_BITS'(r_period_calc);
    assign w_new_due  = r_now + w_add_opnd;

    // due test at cell 0: signed wrap difference zero or negative
    assign w_diff     = w_due[0] - r_now;
    assign w_is_due   = (w_diff == '0) || w_diff[TIME_BITS-1];
    assign w_in_use   = CNT_W'(r_k) < r_used;
    assign w_cand     = w_in_use && !w_queued[0] && w_is_due;
    assign w_runs_inc = w_runs[0] + RUNS_W'(1);

    // with a nonempty queue the stored head runs; otherwise the first due
    // entry goes through the queue and straight out again
    assign w_disp   = (r_state == ST_SCAN) &&
                      (r_fifo_had ? (w_in_use && (r_k == r_pop_idx))
                                  : (w_cand && !r_got));
    assign w_append = (r_state == ST_SCAN) && w_cand;
    assign w_pop    = (r_state == ST_SCAN) && (r_k == LAST_IDX) && (r_got || w_disp);

    assign w_back_due    = w_disp ? w_new_due : w_due[0];
    assign w_back_queued = w_disp ? 1'b0 : (w_append ? 1'b1 : w_queued[0]);
    assign w_back_runs   = w_disp ? w_runs_inc : w_runs[0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (t_cmd'(i_command))
                        CMD_REGISTER: n_state = (r_used == FULL_CNT) ? ST_DONE : ST_MUL;
                        CMD_PROCESS:  n_state = ST_PREP;
                        CMD_CLEAR,
                        CMD_NOP:      n_state = ST_DONE;
                    endcase
                end
            end
            ST_MUL:   n_state = ST_WRITE;
            ST_WRITE: n_state = ST_DONE;
            ST_PREP:  n_state = ST_SCAN;
            ST_SCAN:  n_state = (r_k == LAST_IDX) ? ST_DONE : ST_SCAN;
            ST_DONE:  n_state = w_res_load ? ST_IDLE : ST_DONE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs: cell controls and queue write
    always_comb begin
        for (int j = 0; j < MAX_EVENTS; j++) begin
            w_ctl[j].shift = (r_state == ST_SCAN);
            w_ctl[j].load  = (r_state == ST_WRITE) && (r_used == CNT_W'(j));
            w_ctl[j].clr_q = w_in_acc && (t_cmd'(i_command) == CMD_CLEAR);
        end
        w_ram_we = w_append;
    end

    // datapath and counters
    always_comb begin
        n_used        = r_used;
        n_head        = r_head;
        n_tail        = r_tail;
        n_fill        = r_fill;
        n_pms         = r_pms;
        n_now         = r_now;
        n_period_calc = r_period_calc;
        n_k           = r_k;
        n_pop_idx     = r_pop_idx;
        n_fifo_had    = r_fifo_had;
        n_got         = r_got;
        n_res_disp    = r_res_disp;
        n_res_id      = r_res_id;
        n_res_runs    = r_res_runs;
        n_res_status  = r_res_status;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_disp    = r_out_disp;
        n_out_id      = r_out_id;
        n_out_runs    = r_out_runs;
        n_out_status  = r_out_status;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_pms        = i_period_ms;
                    n_now        = i_now_us;
                    n_res_disp   = 1'b0;
                    n_res_id     = '0;
                    n_res_runs   = '0;
                    n_res_status = 1'b0;
                    unique case (t_cmd'(i_command))
                        CMD_CLEAR: begin
                            n_used = '0;
                            n_head = '0;
                            n_tail = '0;
                            n_fill = '0;
                        end
                        CMD_REGISTER: n_res_status = (r_used == FULL_CNT);
                        CMD_PROCESS,
                        CMD_NOP: ;
                    endcase
                end
            end
            ST_MUL: begin
                // 20 x 10 bit product always fits the 30 bit period
                n_period_calc = PERIOD_W'(PERIOD_W'(r_pms) * PERIOD_W'(US_PER_MS));
            end
            ST_WRITE: begin
                n_res_disp = 1'b1;
                n_res_id   = ID_W'(r_used);
                n_res_runs = RUNS_W'(1);
                n_used     = r_used + CNT_W'(1);
            end
            ST_PREP: begin
                n_pop_idx  = w_rd_idx;
                n_fifo_had = (r_fill != '0);
                n_k        = '0;
                n_got      = 1'b0;
            end
            ST_SCAN: begin
                n_k = r_k + IDX_W'(1);
                if (w_append) begin
                    n_tail = (r_tail == LAST_IDX) ? '0 : r_tail + IDX_W'(1);
                end
                if (w_disp) begin
                    n_got      = 1'b1;
                    n_res_disp = 1'b1;
                    n_res_id   = ID_W'(r_k);
                    n_res_runs = w_runs_inc;
                end
                if (w_pop) begin
                    n_head = (r_head == LAST_IDX) ? '0 : r_head + IDX_W'(1);
                end
                n_fill = r_fill + CNT_W'(w_append) - CNT_W'(w_pop);
            end
            ST_DONE: begin
                if (w_res_load) begin
                    n_out_valid  = 1'b1;
                    n_out_disp   = r_res_disp;
                    n_out_id     = r_res_id;
                    n_out_runs   = r_res_runs;
                    n_out_status = r_res_status;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_got       <= 1'b0;
            r_fifo_had  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_got       <= n_got;
            r_fifo_had  <= n_fifo_had;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pms         <= n_pms;
        r_now         <= n_now;
        r_period_calc <= n_period_calc;
        r_k           <= n_k;
        r_pop_idx     <= n_pop_idx;
        r_res_disp    <= n_res_disp;
        r_res_id      <= n_res_id;
        r_res_runs    <= n_res_runs;
        r_res_status  <= n_res_status;
        r_out_disp    <= n_out_disp;
        r_out_id      <= n_out_id;
        r_out_runs    <= n_out_runs;
        r_out_status  <= n_out_status;
    end

    // run queue of table indices; the head is read continuously
    ped_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_EVENTS)
    ) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (r_tail),
        .i_wr_data (r_k),
        .i_rd_addr (r_head),
        .o_rd_data (w_rd_idx)
    );

    // ring of cells: cell j takes cell j+1, the last cell takes processed cell 0
    for (genvar j = 0; j < MAX_EVENTS; j++) begin : g_cell
        logic [PERIOD_W-1:0]  w_nb_period;
        logic [TIME_BITS-1:0] w_nb_due;
        logic                 w_nb_queued;
        logic [RUNS_W-1:0]    w_nb_runs;

        if (j == MAX_EVENTS - 1) begin : g_wrap
            assign w_nb_period = w_period[0];
            assign w_nb_due    = w_back_due;
            assign w_nb_queued = w_back_queued;
            assign w_nb_runs   = w_back_runs;
        end else begin : g_link
            assign w_nb_period = w_period[j+1];
            assign w_nb_due    = w_due[j+1];
            assign w_nb_queued = w_queued[j+1];
            assign w_nb_runs   = w_runs[j+1];
        end

        ped_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl[j]),
            .i_nb_period (w_nb_period),
            .i_nb_due    (w_nb_due),
            .i_nb_queued (w_nb_queued),
            .i_nb_runs   (w_nb_runs),
            .i_wr_period (r_period_calc),
            .i_wr_due    (w_new_due),
            .o_period    (w_period[j]),
            .o_due       (w_due[j]),
            .o_queued    (w_queued[j]),
            .o_runs      (w_runs[j])
        );
    end

    assign o_out_valid     = r_out_valid;
    assign o_dispatched    = r_out_disp;
    assign o_event_id      = r_out_id;
    assign o_run_total     = r_out_runs;
    assign o_result_status = r_out_status;

    // queue never holds more events than the table
    a_fill_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_used)
        else $error("run queue fill exceeds used entries");

    // tail stays head plus fill around the ring
    a_tail_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_head) + int'(r_fill) == int'(r_tail)) ||
        (int'(r_head) + int'(r_fill) == int'(r_tail) + MAX_EVENTS))
        else $error("run queue tail out of step with head and fill");

    // a nonempty queue always yields a dispatch during the pass
    a_head_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_fifo_had && r_k == LAST_IDX) |-> (r_got || w_disp))
        else $error("queued head not found in table pass");

    // a full table answer never carries a dispatch
    a_full_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && t_cmd'(i_command) == CMD_REGISTER && r_used == FULL_CNT)
        |=> (r_state == ST_DONE && r_res_status && !r_res_disp))
        else $error("full table register produced a dispatch");

endmodule

[tb/periodic_event_dispatcher_test.sv]
// self-checking testbench for the periodic event dispatcher
`timescale 1ns / 100ps

module periodic_event_dispatcher_test
    import ped_pkg::*;
();

    localparam int NEV = DEF_MAX_EVENTS;
    localparam int TB  = DEF_TIME_BITS;
    // longest run of cycles with no transaction on either side before giving up
    localparam int WATCHDOG_LIMIT = 2000;

    // one result transaction as the dispatcher should answer it
    typedef struct packed {
        logic              dispatched;
        logic [ID_W-1:0]   event_id;
        logic [RUNS_W-1:0] run_total;
        logic              result_status;
    } t_dispatch_result;

    // clock, reset and the command channel
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cmd_valid = 1'b0;
    logic             cmd_stall;
    t_cmd             cmd_code = CMD_NOP;
    logic [PMS_W-1:0] cmd_period_ms = '0;
    logic [TB-1:0]    cmd_now_us = '0;

    // result channel
    logic              res_valid;
    logic              res_stall = 1'b0;
    logic              res_dispatched;
    logic [ID_W-1:0]   res_event_id;
    logic [RUNS_W-1:0] res_run_total;
    logic              res_status;

    // shadow copy of the event table and run queue
    logic [PERIOD_W-1:0] ev_period [NEV];
    logic [TB-1:0]       ev_due [NEV];
    logic                ev_queued [NEV] = '{default: 1'b0};
    logic [RUNS_W-1:0]   ev_runs [NEV];
    int                  ev_count = 0;
    logic [ID_W-1:0]     pend_ids [NEV];
    int                  rq_head = 0;
    int                  rq_fill = 0;

    // results still owed by the dispatcher, oldest first
    t_dispatch_result awaited_dispatches [$];

    int            src_idle_pct = 0;
    int            sink_idle_pct = 0;
    int            commands_sent = 0;
    int            results_checked = 0;
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    logic [TB-1:0] clock_us = '0;

    periodic_event_dispatcher #(
        .MAX_EVENTS(NEV),
        .TIME_BITS (TB)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (cmd_valid),
        .o_in_stall     (cmd_stall),
        .i_command      (cmd_code),
        .i_period_ms    (cmd_period_ms),
        .i_now_us       (cmd_now_us),
        .o_out_valid    (res_valid),
        .i_out_stall    (res_stall),
        .o_dispatched   (res_dispatched),
        .o_event_id     (res_event_id),
        .o_run_total    (res_run_total),
        .o_result_status(res_status)
    );

    // 4 ns clock
    initial begin
        forever #2 clk = ~clk;
    end

    // run one event: bump its count, drop its queued mark, schedule the next run
    function automatic t_dispatch_result run_event(input int idx, input logic [TB-1:0] now);
        t_dispatch_result r;
        ev_runs[idx]    = ev_runs[idx] + 1'b1;
        ev_queued[idx]  = 1'b0;
        ev_due[idx]     = now + TB'(ev_period[idx]);
        r.dispatched    = 1'b1;
        r.event_id      = ID_W'(idx);
        r.run_total     = ev_runs[idx];
        r.result_status = 1'b0;
        return r;
    endfunction

    // advance the shadow table by one command and give the answer it should produce
    function automatic t_dispatch_result predict_dispatch(input t_cmd cmd,
                                                          input logic [PMS_W-1:0] pms,
                                                          input logic [TB-1:0] now);
        t_dispatch_result r;
        logic [TB-1:0]    lead;
        int               slot;
        r = '0;
        case (cmd)
            CMD_CLEAR: begin
                foreach (ev_queued[i]) ev_queued[i] = 1'b0;
                ev_count = 0;
                rq_head  = 0;
                rq_fill  = 0;
            end
            CMD_REGISTER: begin
                if (ev_count >= NEV) begin
                    // table full, nothing changes
                    r.result_status = 1'b1;
                end else begin
                    ev_period[ev_count] = PERIOD_W'(32'(pms) * 32'(US_PER_MS));
                    ev_runs[ev_count]   = '0;
                    ev_count++;
                    r = run_event(ev_count - 1, now);
                end
            end
            CMD_PROCESS: begin
                // scan in index order, queue whatever is due and not yet queued
                for (int i = 0; i < ev_count; i++) begin
                    lead = ev_due[i] - now;
                    if (!ev_queued[i] && (lead == '0 || lead[TB-1]) && rq_fill < NEV) begin
                        pend_ids[(rq_head + rq_fill) % NEV] = ID_W'(i);
                        rq_fill++;
                        ev_queued[i] = 1'b1;
                    end
                end
                // then run the head of the queue, if any
                if (rq_fill != 0) begin
                    slot    = pend_ids[rq_head];
                    rq_head = (rq_head + 1) % NEV;
                    rq_fill--;
                    r = run_event(slot, now);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [TB-1:0] random_time();
        return TB'({$urandom(), $urandom()});
    endfunction

    function automatic logic [PMS_W-1:0] random_period();
        return PMS_W'($urandom());
    endfunction

    // mostly a few ms so that events come due often, now and then any period
    function automatic logic [PMS_W-1:0] short_period();
        if ($urandom_range(7) == 0)
            return random_period();
        return PMS_W'($urandom_range(6));
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("tb: mismatch at result %0d: %s", results_checked, what);
    endtask

    // one command transaction, with random idle cycles ahead of it
    task automatic send_command(input t_cmd cmd, input logic [PMS_W-1:0] pms,
                                input logic [TB-1:0] now);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid     <= 1'b1;
        cmd_code      <= cmd;
        cmd_period_ms <= pms;
        cmd_now_us    <= now;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        // accepted at this edge
        awaited_dispatches.insert(awaited_dispatches.size(), predict_dispatch(cmd, pms, now));
        commands_sent++;
    endtask

    // hold off the command side until every owed result is in
    task automatic wait_results_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (awaited_dispatches.size() != 0) @(posedge clk);
    endtask

    // clear, fill the table, then a run of process steps with time moving on
    task automatic run_schedule_episode();
        int   n_reg;
        t_cmd op;
        if ($urandom_range(3) == 0)
            clock_us = '1 - TB'($urandom_range(40000));   // wrap of the time counter soon
        else
            clock_us = random_time();
        send_command(CMD_CLEAR, random_period(), clock_us);
        if ($urandom_range(5) == 0)
            n_reg = $urandom_range(NEV, NEV + 3);         // runs into a full table
        else
            n_reg = $urandom_range(1, NEV);
        repeat (n_reg) begin
            clock_us += TB'($urandom_range(400));
            send_command(CMD_REGISTER, short_period(), clock_us);
        end
        repeat ($urandom_range(6, 40)) begin
            clock_us += TB'($urandom_range(2500));
            if ($urandom_range(49) == 0)
                clock_us += random_time();                // jump far, either way by sign
            op = ($urandom_range(11) == 0) ? CMD_REGISTER : CMD_PROCESS;
            send_command(op, short_period(), clock_us);
        end
    endtask

    // field extremes, empty queue, unused command and the due boundary
    task automatic test_field_extremes();
        send_command(CMD_PROCESS, '0, '0);                          // empty table
        send_command(CMD_REGISTER, '0, 48'hAAAA_AAAA_AAAA);
        send_command(CMD_REGISTER, '1, 48'hFFFF_FFFF_FFFF);         // due wraps past zero
        send_command(CMD_PROCESS, '0, 48'h2AAA_AAAA_AAAA);          // difference of exactly half range
        send_command(CMD_PROCESS, '1, 48'hAAAA_AAAA_AAAB);          // one short of half range
        send_command(CMD_PROCESS, '0, 48'hAAAA_AAAA_AAAB);          // nothing due, queue empty
        send_command(CMD_NOP, '1, '1);
        send_command(CMD_PROCESS, 20'h5_5555, 48'h5555_5555_5555);
        send_command(CMD_CLEAR, '1, '1);
        send_command(CMD_PROCESS, '0, '0);                          // table emptied by clear
    endtask

    // sixteen events, then one more that does not fit
    task automatic test_table_full();
        clock_us = random_time();
        send_command(CMD_CLEAR, '0, clock_us);
        repeat (NEV) begin
            clock_us += TB'($urandom_range(300));
            send_command(CMD_REGISTER, short_period(), clock_us);
        end
        send_command(CMD_REGISTER, '1, clock_us);
        clock_us += TB'(3000);
        send_command(CMD_PROCESS, '0, clock_us);
    endtask

    // sender goes quiet until the block has answered everything, then resumes
    task automatic test_drain_pause();
        run_schedule_episode();
        wait_results_drained();
        send_command(CMD_PROCESS, random_period(), clock_us + TB'(5000));
        send_command(CMD_REGISTER, short_period(), clock_us + TB'(6000));
    endtask

    // well-formed schedules with random content, some noise mixed in
    task automatic test_random_schedule(input int src_pct, input int snk_pct,
                                        input int quota);
        int target;
        src_idle_pct  = src_pct;
        sink_idle_pct = snk_pct;
        target = commands_sent + quota;
        while (commands_sent < target) begin
            case ($urandom_range(9))
                0: begin
                    repeat ($urandom_range(1, 4))
                        send_command(t_cmd'($urandom_range(3)), random_period(),
                                     random_time());
                end
                1: begin
                    wait_results_drained();
                    run_schedule_episode();
                end
                default: run_schedule_episode();
            endcase
        end
    endtask

    // result checking, receiver stalls and the watchdog
    always @(posedge clk) begin : result_checker
        t_dispatch_result want;
        if (rst_n && res_valid && !res_stall) begin
            if (awaited_dispatches.size() == 0) begin
                flag_mismatch("result transaction with nothing expected");
            end else begin
                want = awaited_dispatches[0];
                awaited_dispatches.delete(0);
                if (res_dispatched !== want.dispatched)
                    flag_mismatch($sformatf("dispatched %0b, expected %0b",
                                            res_dispatched, want.dispatched));
                if (res_event_id !== want.event_id)
                    flag_mismatch($sformatf("event_id %0h, expected %0h",
                                            res_event_id, want.event_id));
                if (res_run_total !== want.run_total)
                    flag_mismatch($sformatf("run_total %0h, expected %0h",
                                            res_run_total, want.run_total));
                if (res_status !== want.result_status)
                    flag_mismatch($sformatf("result_status %0b, expected %0b",
                                            res_status, want.result_status));
            end
            results_checked++;
        end
        if ((res_valid && !res_stall) || (cmd_valid && !cmd_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            res_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    // test sequence
    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        src_idle_pct  = 35;
        sink_idle_pct = 53;
        test_field_extremes();
        test_table_full();
        test_drain_pause();
        test_random_schedule(35, 53, 480);
        test_random_schedule(53, 35, 480);
        test_random_schedule(0, 0, 480);
        // let the block answer the last commands, then watch for strays
        wait_results_drained();
        repeat (NEV + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
sv/ped_pkg.sv
sv/ped_ram.sv
sv/ped_cell.sv
sv/periodic_event_dispatcher.sv
tb/periodic_event_dispatcher_test.sv
